// File: hdl/double_hash_table_cache_top_macros.svh
// Assertion helpers used by the table controller RTL.
`ifndef DOUBLE_HASH_TABLE_CACHE_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_CACHE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DHTC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhtc assertion failed");
// next-cycle implication
`define DHTC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhtc assertion failed");
`else
`define DHTC_ASSERT_SAME(name, clk, rst, ante, cons)
`define DHTC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: hdl/dhtc_pkg.sv
package dhtc_pkg;

   localparam logic [1:0] CMD_GET = 2'd0;
   localparam logic [1:0] CMD_SET = 2'd1;
   localparam logic [1:0] CMD_DEL = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [31:0] HASH_MUL   = 32'd2654435769;
   localparam logic [31:0] TAG_TOP    = 32'h8000_0000;
   localparam logic [31:0] MARK_EMPTY = 32'd0;
   localparam logic [31:0] MARK_DEAD  = 32'd1;

   localparam logic [7:0] MAX_ENTRIES_RESET = 8'd128;

   // remainder unit: bits of tag/step consumed per cycle
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = 32 / MOD_BITS;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] value;
   } dhtc_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [7:0]  slot;
   } dhtc_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_STEP,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } dhtc_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic tag_mul;
      logic step_mul;
      logic mod_step;
      logic read;
      logic check;
      logic commit;
   } dhtc_ctl_type;

   typedef struct packed {
      logic clear_last;
      logic mod_last;
      logic probe_stop;
   } dhtc_sts_type;

endpackage

// File: hdl/dhtc_datapath.sv
module dhtc_datapath import dhtc_pkg::*; #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  dhtc_ctl_type ctl,
   output dhtc_sts_type sts,
   input  dhtc_req_type req_data,
   output dhtc_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   // MSB-first remainder: r = (r * 2^MOD_BITS + bits) mod TABLE_SLOTS
   function automatic logic [IDX_W-1:0] mod_shift(input logic [IDX_W-1:0] r,
                                                  input logic [MOD_BITS-1:0] bits);
      logic [IDX_W:0] acc;
      acc = {1'b0, r};
      for (int i = MOD_BITS - 1; i >= 0; i--) begin
         acc = {acc[IDX_W-1:0], bits[i]};
         if (acc >= SLOTS_EXT) begin
            acc = acc - SLOTS_EXT;
         end
      end
      return acc[IDX_W-1:0];
   endfunction

   logic [31:0] tag_mem   [TABLE_SLOTS];
   logic [31:0] key_mem   [TABLE_SLOTS];
   logic [31:0] value_mem [TABLE_SLOTS];

   dhtc_req_type         req_ff, req_in;
   dhtc_rsp_type         rsp_ff, rsp_in;
   logic [31:0]          tag_ff, tag_in;
   logic [31:0]          tag_sh_ff, tag_sh_in;
   logic [31:0]          step_sh_ff, step_sh_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     adv_ff, adv_in;
   logic [IDX_W-1:0]     probe_cnt_ff, probe_cnt_in;
   logic [IDX_W-1:0]     spot_ff, spot_in;
   logic                 spot_ok_ff, spot_ok_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [7:0]           live_ff, live_in;
   logic [7:0]           max_entries_ff, max_entries_in;
   logic [31:0]          tag_rd_ff, key_rd_ff, value_rd_ff;

   logic [31:0]      tag_hash, step_prod;
   logic [IDX_W:0]   idx_sum;
   logic [IDX_W-1:0] next_idx;
   logic             slot_empty, slot_dead, slot_match, probe_last;

   dhtc_rsp_type     res;
   logic             ins_go, del_go;
   logic             tag_we, key_we, value_we;
   logic [31:0]      tag_wd;
   logic [IDX_W-1:0] wr_addr;

   assign tag_hash  = req_ff.key * HASH_MUL;
   assign step_prod = tag_ff * HASH_MUL;

   assign idx_sum  = {1'b0, idx_ff} + {1'b0, adv_ff};
   assign next_idx = (idx_sum >= SLOTS_EXT) ? IDX_W'(idx_sum - SLOTS_EXT)
                                            : idx_sum[IDX_W-1:0];

   // tag always has its top bit set, so it never collides with the marks
   assign slot_empty = (tag_rd_ff == MARK_EMPTY);
   assign slot_dead  = (tag_rd_ff == MARK_DEAD);
   assign slot_match = (tag_rd_ff == tag_ff) && (key_rd_ff == req_ff.key);
   assign probe_last = (probe_cnt_ff == LAST_IDX);

   assign sts.clear_last = (clr_cnt_ff == LAST_IDX);
   assign sts.mod_last   = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
   assign sts.probe_stop = slot_empty || slot_match || probe_last;

   // result and table update for the finished probe
   always_comb begin
      res.status     = STATUS_MISS;
      res.read_value = 32'd0;
      res.slot       = 8'd0;
      ins_go         = 1'b0;
      del_go         = 1'b0;
      value_we       = 1'b0;
      unique case (req_ff.cmd)
         CMD_GET: begin
            if (found_ff) begin
               res.status     = STATUS_OK;
               res.read_value = value_rd_ff;
               res.slot       = 8'(idx_ff);
            end
         end
         CMD_SET: begin
            if (found_ff) begin
               value_we   = 1'b1;
               res.status = STATUS_OK;
               res.slot   = 8'(idx_ff);
            end else if ((live_ff >= max_entries_ff) || !spot_ok_ff) begin
               res.status = STATUS_FULL;
            end else begin
               ins_go     = 1'b1;
               value_we   = 1'b1;
               res.status = STATUS_OK;
               res.slot   = 8'(spot_ff);
            end
         end
         CMD_DEL: begin
            if (found_ff) begin
               del_go     = 1'b1;
               res.status = STATUS_OK;
               res.slot   = 8'(idx_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (ctl.clear) begin
         tag_we   = 1'b1;
         key_we   = 1'b0;
         tag_wd   = MARK_EMPTY;
         wr_addr  = clr_cnt_ff;
      end else begin
         tag_we   = ctl.commit && (ins_go || del_go);
         key_we   = ctl.commit && ins_go;
         tag_wd   = ins_go ? tag_ff : MARK_DEAD;
         wr_addr  = found_ff ? idx_ff : spot_ff;
      end
   end

   always_comb begin
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      tag_in         = tag_ff;
      tag_sh_in      = tag_sh_ff;
      step_sh_in     = step_sh_ff;
      mod_cnt_in     = mod_cnt_ff;
      idx_in         = idx_ff;
      adv_in         = adv_ff;
      probe_cnt_in   = probe_cnt_ff;
      spot_in        = spot_ff;
      spot_ok_in     = spot_ok_ff;
      found_in       = found_ff;
      clr_cnt_in     = clr_cnt_ff;
      live_in        = live_ff;
      max_entries_in = max_entries_ff;

      if (ctl.load) begin
         req_in = req_data;
      end
      if (ctl.tag_mul) begin
         tag_in = tag_hash | TAG_TOP;
      end
      if (ctl.step_mul) begin
         tag_sh_in    = tag_ff;
         step_sh_in   = {step_prod[30:0], 1'b1};
         mod_cnt_in   = '0;
         idx_in       = '0;
         adv_in       = '0;
         probe_cnt_in = '0;
         spot_ok_in   = 1'b0;
         found_in     = 1'b0;
      end
      if (ctl.mod_step) begin
         idx_in     = mod_shift(idx_ff, tag_sh_ff[31 -: MOD_BITS]);
         adv_in     = mod_shift(adv_ff, step_sh_ff[31 -: MOD_BITS]);
         tag_sh_in  = tag_sh_ff << MOD_BITS;
         step_sh_in = step_sh_ff << MOD_BITS;
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end
      if (ctl.check) begin
         // first free slot on the path is where a new key goes
         if ((slot_empty || slot_dead) && !spot_ok_ff) begin
            spot_in    = idx_ff;
            spot_ok_in = 1'b1;
         end
         found_in = slot_match;
         if (!(slot_empty || slot_match || probe_last)) begin
            idx_in       = next_idx;
            probe_cnt_in = probe_cnt_ff + 1'b1;
         end
      end
      if (ctl.clear) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (ctl.commit) begin
         rsp_in = res;
         if (ins_go) begin
            live_in = live_ff + 8'd1;
         end else if (del_go && (live_ff != 8'd0)) begin
            live_in = live_ff - 8'd1;
         end
      end
      if (csr_we) begin
         max_entries_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      tag_ff       <= tag_in;
      tag_sh_ff    <= tag_sh_in;
      step_sh_ff   <= step_sh_in;
      idx_ff       <= idx_in;
      adv_ff       <= adv_in;
      probe_cnt_ff <= probe_cnt_in;
      spot_ff      <= spot_in;
      spot_ok_ff   <= spot_ok_in;
      found_ff     <= found_in;
      if (reset) begin
         mod_cnt_ff     <= '0;
         clr_cnt_ff     <= '0;
         live_ff        <= 8'd0;
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else begin
         mod_cnt_ff     <= mod_cnt_in;
         clr_cnt_ff     <= clr_cnt_in;
         live_ff        <= live_in;
         max_entries_ff <= max_entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= tag_wd;
      end
      if (key_we) begin
         key_mem[wr_addr] <= req_ff.key;
      end
      if (ctl.commit && value_we) begin
         value_mem[wr_addr] <= req_ff.value;
      end
      if (ctl.read) begin
         tag_rd_ff   <= tag_mem[idx_ff];
         key_rd_ff   <= key_mem[idx_ff];
         value_rd_ff <= value_mem[idx_ff];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/dhtc_ctrl.sv
`include "double_hash_table_cache_top_macros.svh"

module dhtc_ctrl import dhtc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dhtc_ctl_type ctl,
   input  dhtc_sts_type sts
);

   dhtc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // output register can take a new item this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_MOD;
         ST_MOD: begin
            if (sts.mod_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = sts.probe_stop ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: ctl.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         ST_HASH:  ctl.tag_mul  = 1'b1;
         ST_STEP:  ctl.step_mul = 1'b1;
         ST_MOD:   ctl.mod_step = 1'b1;
         ST_READ:  ctl.read     = 1'b1;
         ST_CHECK: ctl.check    = 1'b1;
         ST_DONE:  ctl.commit   = out_free;
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DHTC_ASSERT_NEXT(a_accept_hash, clock, reset, req_valid && !req_stall, state_ff == ST_HASH)
   `DHTC_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `DHTC_ASSERT_NEXT(a_clear_holds, clock, reset, (state_ff == ST_CLEAR) && !sts.clear_last, state_ff == ST_CLEAR)
   `DHTC_ASSERT_NEXT(a_commit_idle, clock, reset, ctl.commit, (state_ff == ST_IDLE) && rsp_valid_ff)

endmodule

// File: hdl/double_hash_table_cache_top.sv
// Double-hashed key/value table.
// Input channel req_*: one get/set/delete command per item (cmd, key, value).
// Result channel rsp_*: exactly one item per command (status, read_value, slot).
// Both channels use valid/stall; an item moves when valid is high and stall low.
// csr_we/csr_wdata write the max_entries limit (reset 128); a set of a new key
// at or above that many live entries, or with no free slot, reports full.
// Per command: the key multiply, the step multiply, the 4-bit-per-cycle remainder
// unit, then for each slot probed (1 to TABLE_SLOTS) a read and a compare on the
// slot memory, then the hand-off to the result register.
// One command is in flight at a time; the next item is accepted only once the
// idle state is reached again after the hand-off.
// After reset the tag memory is cleared one slot a cycle, every slot in turn,
// with req_stall held high; csr writes are taken during that pass.
// A result waiting under rsp_stall stays in the output register; the next command
// is accepted and processed meanwhile, and only its hand-off waits for that slot.
module double_hash_table_cache_top import dhtc_pkg::*; #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dhtc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dhtc_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata
);

   dhtc_ctl_type ctl;
   dhtc_sts_type sts;

   dhtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   dhtc_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule
